[rtl/dfn_pkg.sv]
// ----------------------------------------------------------------------------
// dfn_pkg: shared types and codes for the directional focus navigator
// Opcodes, directions, sequencer states and register selects.
// ----------------------------------------------------------------------------
`default_nettype none

package dfn_pkg;

  typedef enum logic [2:0] {
    OP_BEGIN = 3'd0,
    OP_ADD   = 3'd1,
    OP_CLAIM = 3'd2,
    OP_END   = 3'd3,
    OP_CLEAR = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    HEAD_NONE  = 3'd0,
    HEAD_LEFT  = 3'd1,
    HEAD_RIGHT = 3'd2,
    HEAD_UP    = 3'd3,
    HEAD_DOWN  = 3'd4
  } dir_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ANCHOR,
    S_SCAN,
    S_DRAIN
  } state_e;

  // register select, taken from paddr[2]
  typedef enum logic {
    REG_TOL = 1'b0,
    REG_WGT = 1'b1
  } reg_e;

  localparam logic [1:0] STEP_NONE  = 2'b00;
  localparam logic [1:0] STEP_RIGHT = 2'b01;
  localparam logic [1:0] STEP_LEFT  = 2'b11;

  localparam int unsigned ADDR_W     = 3;
  localparam logic [7:0]  TOL_RESET  = 8'd2;
  localparam logic [3:0]  WGT_RESET  = 4'd5;

endpackage

`default_nettype wire

[rtl/directional_focus_navigator.sv]
// ----------------------------------------------------------------------------
// directional_focus_navigator: keyboard/pad focus mover over a rect table
// Double-buffered rectangle table with a per-frame directional focus search.
// ----------------------------------------------------------------------------
// Usage
//   Requests enter on start/busy: a request is taken at a rising edge with
//   start high and busy low. Opcodes: begin frame (latch direction, empty
//   the current bank), add item, claim horizontal, end frame, clear focus.
//   Every request gives exactly one result, shown for a single cycle with
//   done_o high: the cycle after it is taken, or after a search the cycle
//   in which busy falls.
//   The receiver cannot stall; results are simply presented and gone.
// Throughput
//   Begin, add, claim, clear and an end frame that needs no search never
//   raise busy, so these may follow back to back.
//   An end frame that moves an existing focus scans the previous bank
//   through the table RAM's single read port, one entry a cycle, into the
//   score pipe, and holds busy until the pipe has drained.
// Reset
//   rst_ni clears control state: empty tables, focus -1, no pending
//   direction, registers back to tolerance 2 and weight 2.5 (five halves).
//   Table contents are not cleared; only entries loaded are ever read.
// Config: APB, tolerance at 0x0, weight at 0x4; write only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module directional_focus_navigator
  import dfn_pkg::*;
#(
  parameter int unsigned MAX_ITEMS  = 64,
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // request channel
  input  wire logic                  start,
  output      logic                  busy,
  input  wire logic [2:0]            opcode_i,
  input  wire logic [2:0]            direction_i,
  input  wire logic [COORD_BITS-1:0] rect_x_i,
  input  wire logic [COORD_BITS-1:0] rect_y_i,
  input  wire logic [COORD_BITS-1:0] rect_w_i,
  input  wire logic [COORD_BITS-1:0] rect_h_i,
  // result channel
  output      logic                  done_o,
  output      logic                  item_focused_o,
  output      logic                  item_dropped_o,
  output      logic signed [1:0]     horizontal_step_o,
  output      logic signed [6:0]     focus_index_o,
  output      logic                  focus_moved_o,
  output      logic                  nav_active_o,
  // APB config
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_W-1:0]     paddr,
  input  wire logic [31:0]           pwdata,
  output      logic [31:0]           prdata,
  output      logic                  pready
);

  localparam int unsigned IW = $clog2(MAX_ITEMS);      // slot index
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);  // item count
  localparam int unsigned FW = IW + 1;                 // signed focus
  localparam int unsigned XW = IW + 2;                 // compare width
  localparam int unsigned AW = $clog2(2 * MAX_ITEMS);  // RAM address
  localparam int unsigned EW = 4 * COORD_BITS;         // packed entry
  localparam int unsigned PW = COORD_BITS + 2;         // doubled centre
  localparam int unsigned DW = COORD_BITS + 3;         // signed delta
  localparam int unsigned SW = COORD_BITS + 7;         // score

  // ---------------------------------------------------------------- config
  logic [7:0] tol_q;
  logic [3:0] wgt_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
      wgt_q <= WGT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_e'(paddr[2]))
        REG_TOL: tol_q <= pwdata[7:0];
        REG_WGT: wgt_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_e'(paddr[2]))
      REG_TOL: prdata = {24'b0, tol_q};
      REG_WGT: prdata = {28'b0, wgt_q};
      default: prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- helpers
  function automatic logic [AW-1:0] addr_of(input logic b, input logic [IW-1:0] i);
    return b ? AW'(MAX_ITEMS) + AW'(i) : AW'(i);
  endfunction

  // focus is held below the count of the new table; empty table gives -1
  function automatic logic signed [FW-1:0] clamp_focus(input logic signed [FW-1:0] f,
                                                       input logic [CW-1:0] c);
    logic signed [XW-1:0] fx;
    logic signed [XW-1:0] cx;
    fx = XW'(f);
    cx = $signed({1'b0, (XW-1)'(c)});
    if (fx >= cx) begin
      return $signed(FW'(c) - FW'(1));
    end
    return f;
  endfunction

  function automatic logic [PW-1:0] centre(input logic [COORD_BITS-1:0] p,
                                           input logic [COORD_BITS-1:0] s);
    return PW'({p, 1'b0}) + PW'(s);
  endfunction

  // ---------------------------------------------------------------- state
  state_e               state_q, state_d;
  logic                 bank_q, bank_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        last_q, last_d;
  logic signed [FW-1:0] focus_q, focus_d;
  dir_e                 pend_q, pend_d;
  logic                 active_q, active_d;

  // scan control
  logic [IW-1:0]        issue_q, issue_d;
  logic                 rdv_q, rdv_d;
  logic [IW-1:0]        rdidx_q, rdidx_d;
  logic                 found_q, found_d;
  logic [IW-1:0]        best_idx_q, best_idx_d;
  logic [SW-1:0]        best_score_q, best_score_d;

  // result registers
  logic                 done_q, done_d;
  logic                 foc_q, foc_d;
  logic                 drop_q, drop_d;
  logic [1:0]           step_q, step_d;
  logic [6:0]           fidx_q, fidx_d;
  logic                 moved_q, moved_d;
  logic                 nav_q, nav_d;

  // datapath
  logic [PW-1:0]        ax_q, ay_q;
  logic                 v1_q, v2_q;
  logic [IW-1:0]        idx1_q, idx2_q;
  logic signed [DW-1:0] dx_q, dy_q;
  logic                 ok2_q;
  logic [SW-1:0]        score2_q;

  // RAM ports
  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [EW-1:0]        rdata;

  logic                 accept;
  logic                 launch;
  logic                 mv;
  logic signed [FW-1:0] nf;
  logic signed [31:0]   focus_wide;

  // ---------------------------------------------------------------- table
  dfn_ram #(
    .WIDTH (EW),
    .DEPTH (2 * MAX_ITEMS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i ({rect_h_i, rect_w_i, rect_y_i, rect_x_i}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      bank_q       <= 1'b0;
      count_q      <= '0;
      last_q       <= '0;
      focus_q      <= '1;
      pend_q       <= HEAD_NONE;
      active_q     <= 1'b0;
      issue_q      <= '0;
      rdv_q        <= 1'b0;
      rdidx_q      <= '0;
      found_q      <= 1'b0;
      best_idx_q   <= '0;
      best_score_q <= '0;
      done_q       <= 1'b0;
      foc_q        <= 1'b0;
      drop_q       <= 1'b0;
      step_q       <= STEP_NONE;
      fidx_q       <= '1;
      moved_q      <= 1'b0;
      nav_q        <= 1'b0;
    end else begin
      state_q      <= state_d;
      bank_q       <= bank_d;
      count_q      <= count_d;
      last_q       <= last_d;
      focus_q      <= focus_d;
      pend_q       <= pend_d;
      active_q     <= active_d;
      issue_q      <= issue_d;
      rdv_q        <= rdv_d;
      rdidx_q      <= rdidx_d;
      found_q      <= found_d;
      best_idx_q   <= best_idx_d;
      best_score_q <= best_score_d;
      done_q       <= done_d;
      foc_q        <= foc_d;
      drop_q       <= drop_d;
      step_q       <= step_d;
      fidx_q       <= fidx_d;
      moved_q      <= moved_d;
      nav_q        <= nav_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    bank_d       = bank_q;
    count_d      = count_q;
    last_d       = last_q;
    focus_d      = focus_q;
    pend_d       = pend_q;
    active_d     = active_q;
    issue_d      = issue_q;
    rdv_d        = 1'b0;
    rdidx_d      = rdidx_q;
    found_d      = found_q;
    best_idx_d   = best_idx_q;
    best_score_d = best_score_q;
    done_d       = 1'b0;
    foc_d        = 1'b0;
    drop_d       = 1'b0;
    step_d       = STEP_NONE;
    moved_d      = 1'b0;
    we           = 1'b0;
    waddr        = addr_of(bank_q, count_q[IW-1:0]);
    raddr        = addr_of(~bank_q, issue_q);
    launch       = 1'b0;
    mv           = (pend_q != HEAD_NONE) && (last_q != '0);
    nf           = focus_q;

    // best-so-far update from the last pipe stage; lowest index wins ties
    if (v2_q && ok2_q && (!found_q || score2_q < best_score_q)) begin
      found_d      = 1'b1;
      best_idx_d   = idx2_q;
      best_score_d = score2_q;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          done_d = 1'b1;
          case (op_e'(opcode_i))
            OP_BEGIN: begin
              pend_d  = (direction_i <= HEAD_DOWN) ? dir_e'(direction_i) : HEAD_NONE;
              count_d = '0;
            end
            OP_ADD: begin
              if (count_q >= CW'(MAX_ITEMS)) begin
                drop_d = 1'b1;
              end else begin
                we      = 1'b1;
                count_d = count_q + CW'(1);
                foc_d   = ($signed({1'b0, (XW-1)'(count_q)}) == XW'(focus_q));
              end
            end
            OP_CLAIM: begin
              case (pend_q)
                HEAD_LEFT: begin
                  step_d = STEP_LEFT;
                  pend_d = HEAD_NONE;
                end
                HEAD_RIGHT: begin
                  step_d = STEP_RIGHT;
                  pend_d = HEAD_NONE;
                end
                default: ;
              endcase
            end
            OP_END: begin
              if (mv && !focus_q[FW-1] &&
                  XW'(focus_q) < $signed({1'b0, (XW-1)'(last_q)})) begin
                // search needed: fetch the anchor entry first
                launch  = 1'b1;
                done_d  = 1'b0;
                found_d = 1'b0;
                raddr   = addr_of(~bank_q, focus_q[IW-1:0]);
                state_d = S_ANCHOR;
              end else begin
                if (mv) begin
                  active_d = 1'b1;
                  if (focus_q[FW-1]) begin
                    nf      = '0;
                    moved_d = 1'b1;
                  end
                end
                pend_d  = HEAD_NONE;
                bank_d  = ~bank_q;
                last_d  = count_q;
                focus_d = clamp_focus(nf, count_q);
              end
            end
            OP_CLEAR: begin
              focus_d  = '1;
              pend_d   = HEAD_NONE;
              active_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_ANCHOR: begin
        issue_d = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        rdv_d   = 1'b1;
        rdidx_d = issue_q;
        if (CW'(issue_q) == last_q - CW'(1)) begin
          state_d = S_DRAIN;
        end else begin
          issue_d = issue_q + IW'(1);
        end
      end
      S_DRAIN: begin
        if (!rdv_q && !v1_q && !v2_q) begin
          nf       = found_q ? $signed({1'b0, best_idx_q}) : focus_q;
          moved_d  = found_q;
          active_d = 1'b1;
          pend_d   = HEAD_NONE;
          bank_d   = ~bank_q;
          last_d   = count_q;
          focus_d  = clamp_focus(nf, count_q);
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    focus_wide = 32'(focus_d);
    fidx_d     = focus_wide[6:0];
    nav_d      = active_d;
  end

  // ---------------------------------------------------------------- score pipe
  // stage 1: deltas of doubled centres; stage 2: along/across and score
  logic signed [DW-1:0] along2;
  logic signed [DW-1:0] across_s;
  logic signed [DW-1:0] tol2;
  logic [PW-1:0]        across2;
  logic                 ok2;
  logic [SW-1:0]        score2;

  always_comb begin
    case (pend_q)
      HEAD_LEFT: begin
        along2   = -dx_q;
        across_s = dy_q[DW-1] ? -dy_q : dy_q;
      end
      HEAD_RIGHT: begin
        along2   = dx_q;
        across_s = dy_q[DW-1] ? -dy_q : dy_q;
      end
      HEAD_UP: begin
        along2   = -dy_q;
        across_s = dx_q[DW-1] ? -dx_q : dx_q;
      end
      default: begin
        along2   = dy_q;
        across_s = dx_q[DW-1] ? -dx_q : dx_q;
      end
    endcase
    across2 = across_s[PW-1:0];
    tol2    = $signed(DW'({tol_q, 1'b0}));
    ok2     = (idx1_q != focus_q[IW-1:0]) && (along2 > tol2);
    score2  = (SW'(along2[PW-1:0]) << 1) + SW'(across2) * SW'(wgt_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= rdv_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_ANCHOR) begin
      ax_q <= centre(rdata[COORD_BITS-1:0], rdata[3*COORD_BITS-1:2*COORD_BITS]);
      ay_q <= centre(rdata[2*COORD_BITS-1:COORD_BITS], rdata[4*COORD_BITS-1:3*COORD_BITS]);
    end
    idx1_q   <= rdidx_q;
    dx_q     <= $signed({1'b0, centre(rdata[COORD_BITS-1:0],
                                      rdata[3*COORD_BITS-1:2*COORD_BITS])})
              - $signed({1'b0, ax_q});
    dy_q     <= $signed({1'b0, centre(rdata[2*COORD_BITS-1:COORD_BITS],
                                      rdata[4*COORD_BITS-1:3*COORD_BITS])})
              - $signed({1'b0, ay_q});
    idx2_q   <= idx1_q;
    ok2_q    <= ok2;
    score2_q <= score2;
  end

  // ---------------------------------------------------------------- outputs
  assign done_o            = done_q;
  assign item_focused_o    = foc_q;
  assign item_dropped_o    = drop_q;
  assign horizontal_step_o = $signed(step_q);
  assign focus_index_o     = $signed(fidx_q);
  assign focus_moved_o     = moved_q;
  assign nav_active_o      = nav_q;

  // ---------------------------------------------------------------- checks
  // a request that needs no search answers on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !launch) |=> done_q)
    else $error("short request gave no result");

  // results only appear once the sequencer is back in idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == S_IDLE))
    else $error("result shown while searching");

  // focus always lies below the previous table's count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    XW'(focus_q) < $signed({1'b0, (XW-1)'(last_q)}))
    else $error("focus outside table");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ITEMS))
    else $error("item count overflow");

  // score pipe only carries data during a scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> (state_q == S_SCAN || state_q == S_DRAIN))
    else $error("score pipe active outside scan");

endmodule

`default_nettype wire

[rtl/dfn_ram.sv]
// ----------------------------------------------------------------------------
// dfn_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module dfn_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[bench/directional_focus_navigator_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// directional_focus_navigator_tb: self-checking bench for the focus navigator
// Sends frames of begin/add/claim/end/clear requests with random spacing. A
// scoreboard class keeps a shadow of the rectangle banks, counts, focus and
// pending direction, and works out the status word for every request it
// sees accepted. Each done_o strobe is checked in order against it. APB
// sets tolerance and weight between phases, the extremes among them, and
// reads both back.
// ----------------------------------------------------------------------------

module directional_focus_navigator_tb;
  import dfn_pkg::*;

  localparam int unsigned MAX_ITEMS   = 64;
  localparam int unsigned COORD_BITS  = 12;
  localparam int          ITEM_TARGET = 1800;
  localparam int          PHASES      = 7;
  localparam int          STALL_LIMIT = 4000;
  // longest search scans a full table, then drains the score pipe; leave a margin on top
  localparam int          SETTLE      = MAX_ITEMS + 16;
  localparam int          REPORT_MAX  = 10;
  localparam int          OPCODE_TOP  = 7;
  localparam int          DIR_TOP     = 7;
  localparam int          COORD_TOP   = (1 << COORD_BITS) - 1;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
  } rect_t;

  // field order matches the concatenation taken off the result ports
  typedef struct packed {
    logic       focused;
    logic       dropped;
    logic [1:0] step;
    logic [6:0] index;
    logic       moved;
    logic       active;
  } status_t;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow of the navigator state and the queue of status words
  // still to come back.
  // --------------------------------------------------------------------------
  class focus_tracker;
    rect_t      rects [2*MAX_ITEMS];
    bit         bank;        // bank being loaded this frame
    int         fill;        // entries loaded into the current bank
    int         prev_fill;   // entries in the bank searched at end frame
    int         focus;       // -1 when nothing has focus
    logic [2:0] heading;     // pending direction
    bit         active;
    logic [7:0] tolerance;
    logic [3:0] weight;
    status_t    awaited[$];
    int         failures;

    function new();
      bank      = 1'b0;
      fill      = 0;
      prev_fill = 0;
      focus     = -1;
      heading   = HEAD_NONE;
      active    = 1'b0;
      tolerance = TOL_RESET;
      weight    = WGT_RESET;
      failures  = 0;
    endfunction

    function void set_register(reg_e sel, logic [31:0] value);
      if (sel == REG_TOL) begin
        tolerance = value[7:0];
      end else begin
        weight = value[3:0];
      end
    endfunction

    function void flag(string what);
      failures++;
      if (failures <= REPORT_MAX) begin
        $display("%t mismatch: %s", $time, what);
      end
    endfunction

    // Nearest candidate beyond the tolerance in the given direction, on the
    // previous frame's bank. Centres are doubled so everything is integer;
    // score is 4x (along + across * weight / 2). Lowest index wins a tie.
    function int nearest_in_direction(int from, logic [2:0] dir);
      int    base, ax, ay, dx, dy, along, across, score, best, best_score;
      rect_t a, b;
      if (from < 0 || from >= prev_fill) return from;
      base = bank ? 0 : MAX_ITEMS;
      a    = rects[base + from];
      ax   = 2 * int'(a.x) + int'(a.w);
      ay   = 2 * int'(a.y) + int'(a.h);
      best = -1;
      best_score = 0;
      for (int i = 0; i < prev_fill; i++) begin
        if (i == from) continue;
        b  = rects[base + i];
        dx = 2 * int'(b.x) + int'(b.w) - ax;
        dy = 2 * int'(b.y) + int'(b.h) - ay;
        case (dir)
          HEAD_LEFT: begin
            along  = -dx;
            across = (dy < 0) ? -dy : dy;
          end
          HEAD_RIGHT: begin
            along  = dx;
            across = (dy < 0) ? -dy : dy;
          end
          HEAD_UP: begin
            along  = -dy;
            across = (dx < 0) ? -dx : dx;
          end
          default: begin
            along  = dy;
            across = (dx < 0) ? -dx : dx;
          end
        endcase
        if (along <= 2 * int'(tolerance)) continue;
        score = 2 * along + across * int'(weight);
        if (best < 0 || score < best_score) begin
          best       = i;
          best_score = score;
        end
      end
      return (best >= 0) ? best : from;
    endfunction

    function void take_request(logic [2:0] op, logic [2:0] dir, rect_t r);
      status_t s;
      int      was;
      s = '0;
      case (op)
        OP_BEGIN: begin
          heading = (dir <= HEAD_DOWN) ? dir : HEAD_NONE;
          fill    = 0;
        end
        OP_ADD: begin
          if (fill >= MAX_ITEMS) begin
            s.dropped = 1'b1;
          end else begin
            rects[(bank ? MAX_ITEMS : 0) + fill] = r;
            s.focused = (fill == focus);
            fill++;
          end
        end
        OP_CLAIM: begin
          if (heading == HEAD_LEFT) begin
            heading = HEAD_NONE;
            s.step  = STEP_LEFT;
          end else if (heading == HEAD_RIGHT) begin
            heading = HEAD_NONE;
            s.step  = STEP_RIGHT;
          end
        end
        OP_END: begin
          if (heading != HEAD_NONE && prev_fill > 0) begin
            was     = focus;
            focus   = (focus < 0) ? 0 : nearest_in_direction(focus, heading);
            active  = 1'b1;
            s.moved = (focus != was);
          end
          heading   = HEAD_NONE;
          bank      = ~bank;
          prev_fill = fill;
          // clamp never counts as a move
          if (focus >= prev_fill) focus = prev_fill - 1;
        end
        OP_CLEAR: begin
          focus   = -1;
          heading = HEAD_NONE;
          active  = 1'b0;
        end
        default: ;
      endcase
      s.index  = focus[6:0];
      s.active = active;
      awaited.push_back(s);
    endfunction

    function void check_status(status_t got);
      status_t want;
      if (awaited.size() == 0) begin
        flag($sformatf("status %h with no request outstanding", got));
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        flag($sformatf({"exp/got focused %b/%b dropped %b/%b step %0d/%0d ",
                        "index %0d/%0d moved %b/%b active %b/%b"},
                       want.focused, got.focused, want.dropped, got.dropped,
                       $signed(want.step), $signed(got.step),
                       $signed(want.index), $signed(got.index),
                       want.moved, got.moved, want.active, got.active));
      end
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    // leftover expectations count as failures too
    function int tally();
      return failures + awaited.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block pins
  // --------------------------------------------------------------------------
  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 start         = 1'b0;
  logic                 busy;
  logic [2:0]           opcode_i      = OP_BEGIN;
  logic [2:0]           direction_i   = HEAD_NONE;
  coord_t               rect_x_i      = '0;
  coord_t               rect_y_i      = '0;
  coord_t               rect_w_i      = '0;
  coord_t               rect_h_i      = '0;
  logic                 done_o;
  logic                 item_focused_o;
  logic                 item_dropped_o;
  logic signed [1:0]    horizontal_step_o;
  logic signed [6:0]    focus_index_o;
  logic                 focus_moved_o;
  logic                 nav_active_o;
  logic                 psel          = 1'b0;
  logic                 penable       = 1'b0;
  logic                 pwrite        = 1'b0;
  logic [ADDR_W-1:0]    paddr         = '0;
  logic [31:0]          pwdata        = '0;
  logic [31:0]          prdata;
  logic                 pready;

  focus_tracker board;
  int           gap_max       = 3;  // 0 gives back-to-back requests
  int           requests_sent = 0;
  int           idle_cycles   = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  directional_focus_navigator #(
    .MAX_ITEMS  (MAX_ITEMS),
    .COORD_BITS (COORD_BITS)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .opcode_i          (opcode_i),
    .direction_i       (direction_i),
    .rect_x_i          (rect_x_i),
    .rect_y_i          (rect_y_i),
    .rect_w_i          (rect_w_i),
    .rect_h_i          (rect_h_i),
    .done_o            (done_o),
    .item_focused_o    (item_focused_o),
    .item_dropped_o    (item_dropped_o),
    .horizontal_step_o (horizontal_step_o),
    .focus_index_o     (focus_index_o),
    .focus_moved_o     (focus_moved_o),
    .nav_active_o      (nav_active_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // --------------------------------------------------------------------------
  // Monitor: results are checked before the request taken at the same edge is
  // noted, so the queue order never depends on process scheduling.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        board.check_status(status_t'({item_focused_o, item_dropped_o,
                                      horizontal_step_o, focus_index_o,
                                      focus_moved_o, nav_active_o}));
      end
      if (start && !busy) begin
        board.take_request(opcode_i, direction_i,
                           {rect_x_i, rect_y_i, rect_w_i, rect_h_i});
      end
    end
  end

  // Watchdog: any accepted request, result or APB access counts as progress.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("** directional_focus_navigator: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  function automatic rect_t any_rect();
    return {coord_t'($urandom_range(0, COORD_TOP)), coord_t'($urandom_range(0, COORD_TOP)),
            coord_t'($urandom_range(0, COORD_TOP)), coord_t'($urandom_range(0, COORD_TOP))};
  endfunction

  // Coarse lattice: lots of equal distances, so ties and tolerance edges show.
  function automatic rect_t grid_rect();
    return {coord_t'($urandom_range(0, 7) * 16), coord_t'($urandom_range(0, 7) * 16),
            coord_t'($urandom_range(0, 3) * 4), coord_t'($urandom_range(0, 3) * 4)};
  endfunction

  // Returns at the edge where the request was taken, start still high, so a
  // following request can go out with no gap.
  task automatic send_request(logic [2:0] op, logic [2:0] dir, rect_t r);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start       <= 1'b1;
    opcode_i    <= op;
    direction_i <= dir;
    rect_x_i    <= r.x;
    rect_y_i    <= r.y;
    rect_w_i    <= r.w;
    rect_h_i    <= r.h;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (op <= OP_CLEAR) requests_sent++;
  endtask

  task automatic apb_access(reg_e sel, bit write, logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {sel, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_register(reg_e sel, logic [31:0] value);
    logic [31:0] readback;
    apb_access(sel, 1'b1, value, readback);
    board.set_register(sel, value);
    apb_access(sel, 1'b0, '0, readback);
    if ((sel == REG_TOL) ? (readback[7:0] !== value[7:0])
                         : (readback[3:0] !== value[3:0])) begin
      board.flag($sformatf("register %s read %h, wrote %h", sel.name(), readback, value));
    end
  endtask

  // Drop start, wait for every outstanding status, then let the block go idle.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (board.outstanding() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // One random frame: begin, some adds with an optional claim among them, end.
  // A few draws give stray requests instead.
  task automatic run_frame();
    int         size, claim_at, pick;
    bit         grid;
    logic [2:0] dir;
    gap_max = ($urandom_range(0, 4) == 0) ? 0 : 3;
    pick    = $urandom_range(0, 99);
    if (pick < 5) begin
      case ($urandom_range(0, 4))
        0: send_request(3'($urandom_range(OP_CLEAR + 1, OPCODE_TOP)),
                        3'($urandom_range(0, DIR_TOP)), any_rect());
        1: send_request(OP_CLEAR, 3'($urandom_range(0, DIR_TOP)), any_rect());
        2: send_request(OP_ADD, 3'($urandom_range(0, DIR_TOP)), any_rect());
        3: send_request(OP_CLAIM, 3'($urandom_range(0, DIR_TOP)), any_rect());
        default: send_request(OP_END, 3'($urandom_range(0, DIR_TOP)), any_rect());
      endcase
      return;
    end
    pick = $urandom_range(0, 99);
    if (pick < 82) begin
      dir = 3'($urandom_range(HEAD_LEFT, HEAD_DOWN));
    end else if (pick < 94) begin
      dir = HEAD_NONE;
    end else begin
      dir = 3'($urandom_range(HEAD_DOWN + 1, DIR_TOP));
    end
    // mostly short tables; now and then one that overflows
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      size = $urandom_range(MAX_ITEMS - 4, MAX_ITEMS + 6);
    end else if (pick < 16) begin
      size = $urandom_range(11, 30);
    end else begin
      size = $urandom_range(0, 10);
    end
    claim_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, size) : -1;
    grid     = $urandom_range(0, 1);
    send_request(OP_BEGIN, dir, any_rect());
    for (int i = 0; i <= size; i++) begin
      if (i == claim_at) send_request(OP_CLAIM, 3'($urandom_range(0, DIR_TOP)), any_rect());
      if (i < size) begin
        send_request(OP_ADD, 3'($urandom_range(0, DIR_TOP)),
                     grid ? grid_rect() : any_rect());
      end
    end
    send_request(OP_END, 3'($urandom_range(0, DIR_TOP)), any_rect());
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0] tol;
    logic [3:0] wgt;
    int         failures;
    board = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset register values.
    gap_max = 1;
    // claim with nothing pending; end frame on an empty table, no direction
    send_request(OP_CLAIM, HEAD_NONE, any_rect());
    send_request(OP_END, HEAD_NONE, any_rect());
    // unused opcodes only report status
    for (int op = OP_CLEAR + 1; op <= OPCODE_TOP; op++) begin
      send_request(op[2:0], 3'($urandom_range(0, DIR_TOP)), any_rect());
    end
    // out-of-range direction latches none; field extremes
    send_request(OP_BEGIN, 3'(DIR_TOP), any_rect());
    send_request(OP_ADD, HEAD_NONE, {12'd0, 12'd0, 12'd0, 12'd0});
    send_request(OP_ADD, HEAD_NONE, {12'd4095, 12'd4095, 12'd4095, 12'd4095});
    send_request(OP_ADD, HEAD_NONE, {12'd4095, 12'd0, 12'd0, 12'd4095});
    send_request(OP_END, HEAD_NONE, any_rect());
    // unfocused slot wakes to 0
    send_request(OP_BEGIN, HEAD_RIGHT, any_rect());
    send_request(OP_ADD, HEAD_NONE, {12'd100, 12'd500, 12'd40, 12'd20});
    send_request(OP_ADD, HEAD_NONE, {12'd300, 12'd500, 12'd40, 12'd20});
    send_request(OP_ADD, HEAD_NONE, {12'd500, 12'd100, 12'd40, 12'd20});
    send_request(OP_END, HEAD_NONE, any_rect());
    // left claimed once, second claim finds nothing
    send_request(OP_BEGIN, HEAD_LEFT, any_rect());
    send_request(OP_CLAIM, HEAD_NONE, any_rect());
    send_request(OP_CLAIM, HEAD_NONE, any_rect());
    // vertical pending is not claimed; search upwards
    send_request(OP_BEGIN, HEAD_UP, any_rect());
    send_request(OP_CLAIM, HEAD_NONE, any_rect());
    send_request(OP_ADD, HEAD_NONE, {12'd100, 12'd100, 12'd40, 12'd20});
    send_request(OP_ADD, HEAD_NONE, {12'd100, 12'd900, 12'd40, 12'd20});
    send_request(OP_ADD, HEAD_NONE, {12'd700, 12'd900, 12'd40, 12'd20});
    send_request(OP_END, HEAD_NONE, any_rect());
    // move down, then an empty new table drops focus to none
    send_request(OP_BEGIN, HEAD_DOWN, any_rect());
    send_request(OP_END, HEAD_NONE, any_rect());
    // empty previous table: move skipped, direction still consumed
    send_request(OP_BEGIN, HEAD_RIGHT, any_rect());
    send_request(OP_END, HEAD_NONE, any_rect());
    send_request(OP_CLEAR, HEAD_NONE, any_rect());
    settle();

    // Random phases, each with its own register setting.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin tol = 8'd0;   wgt = 4'd0;  end
        1: begin tol = 8'd255; wgt = 4'd15; end
        2: begin tol = 8'd0;   wgt = 4'd15; end
        3: begin tol = 8'd255; wgt = 4'd0;  end
        PHASES - 1: begin tol = TOL_RESET; wgt = WGT_RESET; end
        default: begin
          tol = 8'($urandom_range(0, 255));
          wgt = 4'($urandom_range(0, 15));
        end
      endcase
      set_register(REG_TOL, {24'd0, tol});
      set_register(REG_WGT, {28'd0, wgt});
      while (requests_sent < (p + 1) * ITEM_TARGET / PHASES) run_frame();
      settle();
    end

    failures = board.tally();
    if (failures == 0) begin
      $display("** directional_focus_navigator: PASSED **");
    end else begin
      $display("** directional_focus_navigator: FAILED **");
    end
    $finish;
  end

endmodule
